// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl of the replay window core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SRW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("srw assertion failed");
`define SRW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srw assertion failed");
`else
`define SRW_ASSERT(lbl, clk, rstn, prop)
`define SRW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/srw_pkg.sv =====
// types and constants of the sequence replay window block
`timescale 1ns / 1ps
package srw_pkg;
  localparam int SEQ_W                = 32;
  localparam int MAX_AHEAD_W          = 8;
  localparam int DEFAULT_WINDOW_DEPTH = 16;

  typedef logic [SEQ_W-1:0]       seq_t;
  typedef logic [1:0]             verdict_t;
  typedef logic [MAX_AHEAD_W-1:0] max_ahead_t;

  localparam max_ahead_t MAX_AHEAD_RESET = 8'd8;

  localparam verdict_t VERDICT_OK      = 2'd0;
  localparam verdict_t VERDICT_BAD     = 2'd1;
  localparam verdict_t VERDICT_CLOSING = 2'd2;
  localparam verdict_t VERDICT_REPLAY  = 2'd3;
endpackage

// ===== hw/rtl/sequence_replay_window_core.sv =====
// an accepted beat goes through stages 1, 2, 3 and the output register to its verdict beat
// throughput: one number per cycle if unstalled, one ring read and one ring write per item
// a ring write and a read of the same slot in one cycle are bypassed inside the ring memory
// reset: expected number 0, max_ahead 8, ring valid bits cleared at once, no clearing pass
// a stall on the output backs up through four stage registers before the input stalls
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sequence_replay_window_core #(
  parameter int WINDOW_DEPTH = srw_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  srw_pkg::max_ahead_t   cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  srw_pkg::seq_t         in_seq_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output srw_pkg::verdict_t     out_verdict
);
  import srw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int X_W    = 18;
  localparam int SHIFT  = X_W + SLOT_W;
  localparam int PROD_W = SHIFT + X_W;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam logic [X_W-1:0] K1        = X_W'((32'd1 << 8) % WINDOW_DEPTH);
  localparam logic [X_W-1:0] K2        = X_W'((32'd1 << 16) % WINDOW_DEPTH);
  localparam logic [X_W-1:0] K3        = X_W'((32'd1 << 24) % WINDOW_DEPTH);
  localparam logic [X_W-1:0] DEPTH_X   = X_W'(WINDOW_DEPTH);
  localparam seq_t           DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);

  max_ahead_t max_ahead_r;
  seq_t       exp_r, exp_nxt;

  logic              v1_r, v2_r, v3_r, out_valid_r;
  seq_t              seq1_r, seq2_r, seq3_r;
  logic [X_W-1:0]    x1_r, x2_r, q2_r, x1_nxt, q2_nxt, slot_full;
  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] slot3_r, slot_nxt;
  verdict_t          verdict_r, verdict_nxt;

  logic rdy_o, rdy3, rdy2, rdy1;
  logic acc, load2, load3, fire3;
  logic wr_ok, is_ahead;
  seq_t diff_ahead, diff_back, ring_data;
  logic ring_vld;

  // handshake chain
  assign rdy_o = !out_valid_r || !out_stall;
  assign fire3 = v3_r && rdy_o;
  assign rdy3  = !v3_r || rdy_o;
  assign load3 = v2_r && rdy3;
  assign rdy2  = !v2_r || rdy3;
  assign load2 = v1_r && rdy2;
  assign rdy1  = !v1_r || rdy2;
  assign acc   = in_valid && rdy1;
  assign in_stall = !rdy1;

  // slot = number mod depth: byte folding, reciprocal multiply, correction
  assign x1_nxt = X_W'(in_seq_number[7:0])
                + X_W'(in_seq_number[15:8])  * K1
                + X_W'(in_seq_number[23:16]) * K2
                + X_W'(in_seq_number[31:24]) * K3;
  assign prod      = PROD_W'(x1_r) * RECIP;
  assign q2_nxt    = prod[PROD_W-1:SHIFT];
  assign slot_full = x2_r - q2_r * DEPTH_X;
  assign slot_nxt  = slot_full[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      exp_r       <= '0;
      max_ahead_r <= MAX_AHEAD_RESET;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_o) out_valid_r <= v3_r;
      if (fire3) exp_r <= exp_nxt;
      if (cfg_wr_en) max_ahead_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      seq1_r <= in_seq_number;
      x1_r   <= x1_nxt;
    end
    if (load2) begin
      seq2_r <= seq1_r;
      x2_r   <= x1_r;
      q2_r   <= q2_nxt;
    end
    if (load3) begin
      seq3_r  <= seq2_r;
      slot3_r <= slot_nxt;
    end
    if (fire3) begin
      verdict_r <= verdict_nxt;
    end
  end

  srw_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (load3),
    .rd_addr (slot_nxt),
    .rd_data (ring_data),
    .rd_vld  (ring_vld),
    .wr_en   (fire3 && wr_ok),
    .wr_addr (slot3_r),
    .wr_data (seq3_r)
  );

  // window check
  assign is_ahead   = seq3_r >= exp_r;
  assign diff_ahead = seq3_r - exp_r;
  assign diff_back  = exp_r - seq3_r;

  always_comb begin
    verdict_nxt = VERDICT_OK;
    wr_ok       = 1'b0;
    exp_nxt     = exp_r;
    if (seq3_r == '0) begin
      verdict_nxt = VERDICT_BAD;
    end else if (seq3_r == '1 || exp_r == '1) begin
      verdict_nxt = VERDICT_CLOSING;
    end else if (is_ahead) begin
      if (diff_ahead > SEQ_W'(max_ahead_r)) begin
        verdict_nxt = VERDICT_BAD;
      end else begin
        wr_ok   = 1'b1;
        exp_nxt = seq3_r + SEQ_W'(1);
      end
    end else if (diff_back > DEPTH_SEQ) begin
      verdict_nxt = VERDICT_BAD;
    end else if (ring_vld && ring_data == seq3_r) begin
      verdict_nxt = VERDICT_REPLAY;
    end else begin
      wr_ok = 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  `SRW_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid_r && !v1_r && !v2_r && !v3_r)
  `SRW_ASSERT(a_exp_hold, clk, rst_n, !fire3 |=> $stable(exp_r))
  `SRW_ASSERT(a_exp_adv, clk, rst_n, fire3 && wr_ok && is_ahead |=> exp_r == $past(exp_nxt))
  `SRW_ASSERT(a_wr_legal, clk, rst_n, fire3 && wr_ok |-> verdict_nxt == VERDICT_OK)
endmodule

// ===== hw/rtl/srw_ring.sv =====
// ring of seen sequence numbers: registered-read memory with per-entry valid bits
`timescale 1ns / 1ps
module srw_ring #(
  parameter int DEPTH  = srw_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SLOT_W = $clog2(srw_pkg::DEFAULT_WINDOW_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output srw_pkg::seq_t     rd_data,
  output logic              rd_vld,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  srw_pkg::seq_t     wr_data
);
  import srw_pkg::*;

  seq_t             mem [0:DEPTH-1];
  logic [DEPTH-1:0] vld_r;
  seq_t             rd_data_r;
  logic             rd_vld_r;
  logic             same_addr;

  assign same_addr = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= same_addr ? wr_data : mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= same_addr ? 1'b1 : vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;
endmodule

// ===== test/sequence_replay_window_core_test.sv =====
// testbench of the sequence replay window core: self-predicting anti-replay checks
`timescale 1ns / 1ps
module sequence_replay_window_core_test;
  import srw_pkg::*;

  localparam int DEPTH = DEFAULT_WINDOW_DEPTH;

  typedef struct {
    seq_t     seq;
    verdict_t verdict;
  } verdict_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  max_ahead_t cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  seq_t       in_seq_number = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  verdict_t   out_verdict;

  seq_t          next_seq;
  seq_t          seen_numbers [DEPTH];
  max_ahead_t    ahead_limit;
  verdict_beat_t pending_verdicts [$];
  int            fail_count = 0;
  int            burst_left = 0;
  int            stall_cycle = 0;
  int            stall_mode = 0;
  int            stall_run = 0;

  sequence_replay_window_core #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_seq_number (in_seq_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_verdict   (out_verdict)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic verdict_t window_verdict(seq_t n);
    int unsigned idx;
    idx = n % DEPTH;
    if (n == '0)
      return VERDICT_BAD;
    if (n == '1 || next_seq == '1)
      return VERDICT_CLOSING;
    if (n >= next_seq) begin
      if (n - next_seq > ahead_limit)
        return VERDICT_BAD;
      next_seq = n + 1;
    end else if (next_seq - n > DEPTH) begin
      return VERDICT_BAD;
    end else if (seen_numbers[idx] == n) begin
      return VERDICT_REPLAY;
    end
    seen_numbers[idx] = n;
    return VERDICT_OK;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_seq(input seq_t n);
    int gap;
    verdict_beat_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_seq_number <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beat.seq = n;
    beat.verdict = window_verdict(n);
    pending_verdicts.push_back(beat);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_ahead(input max_ahead_t v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ahead_limit = v;
  endtask

  function automatic seq_t pick_seq();
    int unsigned roll;
    seq_t slot_val;
    roll = $urandom_range(0, 99);
    slot_val = seen_numbers[$urandom_range(0, DEPTH - 1)];
    if (roll < 45)
      return next_seq + $urandom_range(0, ahead_limit);
    if (roll < 70)
      return next_seq - $urandom_range(1, DEPTH);
    if (roll < 82)
      return (slot_val != '0) ? slot_val : next_seq - 1;
    if (roll < 88)
      return next_seq + ahead_limit + 1;
    if (roll < 92)
      return next_seq - (DEPTH + 1);
    if (roll < 96)
      return $urandom;
    if (roll < 98)
      return '0;
    return '1;
  endfunction

  // receiver stall: the pattern is picked anew at random from four modes (none, random, runs, alternating)
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 128 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 12);
          out_stall <= ~out_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
      default: out_stall <= stall_cycle[0];
    endcase
  end

  // outputs sampled at the falling edge: the values the next rising edge takes
  always @(negedge clk) begin
    verdict_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected verdict beat: got %0d", out_verdict);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want.verdict) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch on seq %08h: expected verdict %0d, got %0d",
                     want.seq, want.verdict, out_verdict);
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_seq(32'd0);
    send_seq(32'hFFFF_FFFF);
    send_seq(32'd9);
    send_seq(32'd3);
    send_seq(32'd3);
    send_seq(32'd11);
    send_seq(32'd20);
    send_seq(32'd19);
    send_seq(32'd19);
    send_seq(32'd5);
    send_seq(32'd4);
    send_seq(32'd21);
    send_seq(32'd30);
    send_seq(32'd40);
    send_seq(32'h8000_0000);
    send_seq(32'hFFFF_FFFE);
    send_seq(32'd0);
    drain();
  endtask

  task automatic test_max_ahead_extremes();
    write_max_ahead('0);
    send_seq(next_seq);
    send_seq(next_seq + 1);
    send_seq(next_seq - 1);
    drain();
    write_max_ahead('1);
    send_seq(next_seq + 255);
    send_seq(next_seq + 256);
    send_seq(next_seq - DEPTH);
    send_seq(next_seq - (DEPTH + 1));
    send_seq(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_random_traffic();
    max_ahead_t limits [6];
    limits = '{8'd255, 8'd0, max_ahead_t'($urandom), 8'd1,
               max_ahead_t'($urandom), MAX_AHEAD_RESET};
    foreach (limits[p]) begin
      write_max_ahead(limits[p]);
      repeat (310) send_seq(pick_seq());
      drain();
    end
  endtask

  initial begin
    next_seq = '0;
    ahead_limit = MAX_AHEAD_RESET;
    foreach (seen_numbers[i]) seen_numbers[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_max_ahead_extremes();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
